// ===== rtl/tjq_pkg.sv =====
// Package for the timer job queue: request and result structs, codes and
// the table entry record. No dependencies.
package tjq_pkg;

	localparam int unsigned MaxResults = 16;

	typedef enum logic [2:0] {
		REQ_TICK   = 3'd0,
		REQ_ONCE   = 3'd1,
		REQ_RECUR  = 3'd2,
		REQ_CANCEL = 3'd3,
		REQ_QUERY  = 3'd4
	} req_code_t;

	typedef enum logic [1:0] {
		KIND_SCHED  = 2'd0,
		KIND_FIRED  = 2'd1,
		KIND_CANCEL = 2'd2,
		KIND_QUERY  = 2'd3
	} kind_code_t;

	typedef struct packed {
		logic [2:0]  req_type;
		logic [30:0] delay;
		logic [30:0] period;
		logic [30:0] job_id;
	} req_t;

	typedef struct packed {
		logic [1:0]  kind;
		logic [30:0] result_id;
		logic        ok;
		logic        last;
	} rsp_t;

	typedef struct packed {
		logic [30:0] id;
		logic [31:0] deadline;
		logic [30:0] period;
		logic [31:0] order;
	} entry_t;

	// Serial-number ordering key: deadline relative to now, offset so that
	// an unsigned compare gives the firing order.
	function automatic logic [31:0] rel_key(input logic [31:0] dl, input logic [31:0] now);
		logic [31:0] d;
		d = dl - now;
		return d ^ 32'h8000_0000;
	endfunction

endpackage

// ===== rtl/tjq_scan.sv =====
// Shared scan comparator of the timer job queue: one table entry per cycle
// while step is high, tracking the earliest due entry, the id match and the
// first free slot. Depends on tjq_pkg.
module tjq_scan
	import tjq_pkg::*;
#(
	parameter int unsigned IdxW = 4
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            start,
	input  logic            step,
	input  logic [IdxW-1:0] idx,
	input  logic            ent_valid,
	input  entry_t          ent,
	input  logic [31:0]     now_time,
	input  logic [30:0]     match_id,
	output logic            best_found,
	output logic [IdxW-1:0] best_idx,
	output logic            hit_found,
	output logic [IdxW-1:0] hit_idx,
	output logic            free_found,
	output logic [IdxW-1:0] free_idx
);

	logic [31:0] best_key_q, best_order_q, key;
	logic        due, better;
	logic        best_found_q, hit_found_q, free_found_q;
	logic [IdxW-1:0] best_idx_q, hit_idx_q, free_idx_q;

	always_comb begin
		key = rel_key(ent.deadline, now_time);
		due = ent_valid && !key[31];
		if (key != best_key_q) begin
			better = key < best_key_q;
		end else begin
			better = (ent.order - best_order_q) >> 31 != 32'd0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			best_found_q <= 1'b0;
			hit_found_q  <= 1'b0;
			free_found_q <= 1'b0;
		end else if (start) begin
			best_found_q <= 1'b0;
			hit_found_q  <= 1'b0;
			free_found_q <= 1'b0;
		end else if (step) begin
			if (due && (!best_found_q || better)) begin
				best_found_q <= 1'b1;
			end
			if (ent_valid && match_id != 31'd0 && ent.id == match_id && !hit_found_q) begin
				hit_found_q <= 1'b1;
			end
			if (!ent_valid && !free_found_q) begin
				free_found_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			if (due && (!best_found_q || better)) begin
				best_idx_q   <= idx;
				best_key_q   <= key;
				best_order_q <= ent.order;
			end
			if (ent_valid && ent.id == match_id && !hit_found_q) begin
				hit_idx_q <= idx;
			end
			if (!ent_valid && !free_found_q) begin
				free_idx_q <= idx;
			end
		end
	end

	assign best_found = best_found_q;
	assign best_idx   = best_idx_q;
	assign hit_found  = hit_found_q;
	assign hit_idx    = hit_idx_q;
	assign free_found = free_found_q;
	assign free_idx   = free_idx_q;

endmodule

// ===== rtl/timer_job_queue.sv =====
// Timer job queue top level: job table memory, sequencer and result register.
// A schedule, cancel or query request is answered after one table scan, and the
// next request is taken once the sequencer is back in idle. A tick that fires
// k jobs, with k below MaxResults, runs k + 1 table scans. A stalled result adds
// its stall. The table scan, one entry a cycle through the shared comparator,
// sets the rate. arst_n clears valid bits, time, counters and the sequencer.
// Uses tjq_pkg.
module timer_job_queue
	import tjq_pkg::*;
#(
	parameter int unsigned MAX_JOBS = 16
) (
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	output logic req_stall,
	input  req_t req,
	output logic rsp_valid,
	input  logic rsp_stall,
	output rsp_t rsp
);

	localparam int unsigned IdxW = $clog2(MAX_JOBS);
	localparam int unsigned CntW = $clog2(MaxResults + 1);

	typedef enum logic [5:0] {
		ST_IDLE  = 6'b000001,
		ST_SCAN  = 6'b000010,
		ST_LAST  = 6'b000100,
		ST_ACT   = 6'b001000,
		ST_EMIT  = 6'b010000,
		ST_WAIT  = 6'b100000
	} state_t;

	state_t          state_q;
	req_t            req_q;
	entry_t          mem [MAX_JOBS];
	entry_t          rd_s1;
	logic [MAX_JOBS-1:0] valid_q;
	logic            rd_valid_s1;
	logic [IdxW:0]   cnt_q;
	logic [IdxW-1:0] rd_idx_s1;
	logic [IdxW-1:0] rd_addr;
	logic [31:0]     now_q, ins_q;
	logic [30:0]     idc_q, idc_inc;
	logic [CntW-1:0] nres_q;
	logic            out_v_q;
	logic            held_q;
	rsp_t            out_q;
	logic            start, step;
	logic            best_found, hit_found, free_found;
	logic [IdxW-1:0] best_idx, hit_idx, free_idx;
	logic            we;
	logic [IdxW-1:0] wa;
	entry_t          wd;

	assign req_stall = state_q != ST_IDLE;
	assign rsp_valid = out_v_q;
	assign rsp       = out_q;
	assign idc_inc   = idc_q + 31'd1;

	// Once the scan has settled, the read port is pointed at the chosen entry.
	assign rd_addr = (state_q == ST_WAIT || state_q == ST_ACT) ? best_idx : cnt_q[IdxW-1:0];

	// Memory read is registered; the scan sees each entry in the cycle after its address.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[wa] <= wd;
		end
		rd_s1     <= mem[rd_addr];
		rd_idx_s1 <= rd_addr;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_valid_s1 <= 1'b0;
		end else begin
			rd_valid_s1 <= valid_q[cnt_q[IdxW-1:0]];
		end
	end

	assign start = state_q == ST_IDLE || state_q == ST_EMIT;
	assign step  = (state_q == ST_SCAN && cnt_q != '0) || state_q == ST_LAST;

	tjq_scan #(.IdxW(IdxW)) u_scan (
		.clk, .arst_n, .start, .step,
		.idx       (rd_idx_s1),
		.ent_valid (rd_valid_s1),
		.ent       (rd_s1),
		.now_time  (now_q),
		.match_id  (req_q.job_id),
		.best_found, .best_idx, .hit_found, .hit_idx, .free_found, .free_idx
	);

	always_comb begin
		we = 1'b0;
		wa = best_idx;
		wd = rd_s1;
		if (state_q == ST_ACT) begin
			if (req_q.req_type == REQ_TICK) begin
				// Fired entry was re-read into rd_s1 by address best_idx.
				we          = best_found && !held_q && rd_s1.period != 31'd0
					&& (!out_v_q || !rsp_stall);
				wd.deadline = now_q + {1'b0, rd_s1.period};
				wd.order    = ins_q;
			end else if (req_q.req_type == REQ_ONCE || req_q.req_type == REQ_RECUR) begin
				we          = free_found;
				wa          = free_idx;
				wd.id       = idc_q;
				wd.deadline = now_q + {1'b0, req_q.delay};
				wd.period   = req_q.req_type == REQ_RECUR ? req_q.period : 31'd0;
				wd.order    = ins_q;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			valid_q <= '0;
			cnt_q   <= '0;
			now_q   <= '0;
			ins_q   <= '0;
			idc_q   <= 31'd1;
			nres_q  <= '0;
			out_v_q <= 1'b0;
			held_q  <= 1'b0;
		end else begin
			if (out_v_q && !rsp_stall) begin
				out_v_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					cnt_q  <= '0;
					nres_q <= '0;
					if (req_valid) begin
						req_q <= req;
						if (req.req_type == REQ_TICK) begin
							now_q   <= now_q + 32'd1;
							state_q <= ST_SCAN;
						end else if (req.req_type == REQ_ONCE || req.req_type == REQ_RECUR
								|| req.req_type == REQ_CANCEL || req.req_type == REQ_QUERY) begin
							state_q <= ST_SCAN;
						end
					end
				end
				ST_SCAN: begin
					if (cnt_q == (IdxW+1)'(MAX_JOBS - 1)) begin
						state_q <= ST_LAST;
					end else begin
						cnt_q <= cnt_q + (IdxW+1)'(1);
					end
				end
				ST_LAST: begin
					state_q <= ST_WAIT;
				end
				ST_WAIT: begin
					state_q <= ST_ACT;
				end
				ST_ACT: begin
					if (held_q) begin
						// The held fired result goes out now that the rescan has
						// shown whether another job follows it.
						out_v_q    <= 1'b1;
						out_q.last <= !best_found;
						held_q     <= 1'b0;
						if (!best_found) begin
							state_q <= ST_IDLE;
						end
					end else if (!out_v_q || !rsp_stall) begin
						out_v_q        <= 1'b0;
						out_q.last     <= 1'b1;
						out_q.ok       <= 1'b0;
						out_q.result_id <= req_q.job_id;
						state_q        <= ST_IDLE;
						case (req_q.req_type)
							REQ_TICK: begin
								if (best_found) begin
									out_q.kind      <= KIND_FIRED;
									out_q.result_id <= rd_s1.id;
									out_q.ok        <= 1'b1;
									nres_q          <= nres_q + CntW'(1);
									if (rd_s1.period != 31'd0) begin
										ins_q <= ins_q + 32'd1;
									end else begin
										valid_q[best_idx] <= 1'b0;
									end
									// At the result limit the request ends here; otherwise
									// the result is held over a rescan.
									if (nres_q == CntW'(MaxResults - 1)) begin
										out_v_q <= 1'b1;
									end else begin
										held_q  <= 1'b1;
										state_q <= ST_EMIT;
									end
								end
							end
							REQ_ONCE, REQ_RECUR: begin
								out_v_q    <= 1'b1;
								out_q.kind <= KIND_SCHED;
								out_q.result_id <= 31'd0;
								if (free_found) begin
									valid_q[free_idx] <= 1'b1;
									out_q.ok        <= 1'b1;
									out_q.result_id <= idc_q;
									idc_q <= idc_inc == 31'd0 ? 31'd1 : idc_inc;
									ins_q <= ins_q + 32'd1;
								end
							end
							REQ_CANCEL: begin
								out_v_q    <= 1'b1;
								out_q.kind <= KIND_CANCEL;
								out_q.ok   <= hit_found;
								if (hit_found) begin
									valid_q[hit_idx] <= 1'b0;
								end
							end
							REQ_QUERY: begin
								out_v_q    <= 1'b1;
								out_q.kind <= KIND_QUERY;
								out_q.ok   <= hit_found;
							end
							default: begin
								out_v_q <= 1'b0;
							end
						endcase
					end
				end
				ST_EMIT: begin
					// A fired result is held; the next scan decides whether it was last.
					cnt_q <= '0;
					state_q <= ST_SCAN;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// The result payload holds while the receiver stalls.
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp));
	a_state_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot(state_q));
	a_held_not_out: assert property (@(posedge clk) disable iff (!arst_n)
		held_q |-> !out_v_q);
	a_busy_stall: assert property (@(posedge clk) disable iff (!arst_n)
		state_q != ST_IDLE |-> req_stall);

endmodule

// ===== tb/sv/timer_job_queue_tb.sv =====
// Self-checking testbench for timer_job_queue: a directed table, then random
// requests, each checked against an in-bench model of the job table.
// Depends on tjq_pkg and the timer_job_queue RTL.
`timescale 1ns / 1ps

module timer_job_queue_tb;
	import tjq_pkg::*;

	localparam int unsigned NumJobs = 16;
	localparam int unsigned RandomRequests = 450;
	localparam int unsigned CycleLimit = 1_000_000;
	localparam int unsigned LongHold = 400;
	localparam logic [31:0] SignBit = 32'h8000_0000;
	localparam logic [30:0] AllOnes31 = 31'h7fff_ffff;

	typedef struct {
		req_t r;
		bit   typed;
		int   count;
		rsp_t want;
	} step_row_t;

	logic clk;
	logic arst_n;
	logic req_valid;
	logic req_stall;
	req_t req;
	logic rsp_valid;
	logic rsp_stall;
	rsp_t rsp;

	// Job table as the block should hold it.
	bit          job_live[NumJobs];
	logic [30:0] job_ident[NumJobs];
	logic [31:0] job_due[NumJobs];
	logic [30:0] job_reload[NumJobs];
	logic [31:0] job_seq[NumJobs];
	logic [31:0] now_ticks;
	logic [30:0] next_ident;
	logic [31:0] next_seq;

	rsp_t pending_rsps[$];
	step_row_t steps[$];
	int errors;
	int unsigned cycles;
	bit hold_receiver;
	bit quiet;

	timer_job_queue #(.MAX_JOBS(NumJobs)) u_top (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.req(req),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.rsp(rsp)
	);

	always begin
		clk = 1'b0;
		#2;
		clk = 1'b1;
		#2;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CycleLimit) begin
			$display("%0t: timeout with %0d results outstanding", $time, pending_rsps.size());
			$display("** timer_job_queue: FAILED **");
			$finish;
		end
	end

	function automatic rsp_t mk_rsp(kind_code_t k, logic [30:0] id, logic ok, logic lst);
		rsp_t x;
		x.kind = k;
		x.result_id = id;
		x.ok = ok;
		x.last = lst;
		return x;
	endfunction

	function automatic req_t mk_req(logic [2:0] t, logic [30:0] d, logic [30:0] p,
			logic [30:0] id);
		req_t x;
		x.req_type = t;
		x.delay = d;
		x.period = p;
		x.job_id = id;
		return x;
	endfunction

	function automatic int lookup_job(logic [30:0] id);
		if (id == 0)
			return -1;
		for (int i = 0; i < NumJobs; i++)
			if (job_live[i] && job_ident[i] == id)
				return i;
		return -1;
	endfunction

	// Applies one request to the table and returns the results it causes.
	function automatic void apply_request(req_t r, ref rsp_t outs[$]);
		int slot;
		int best;
		logic [31:0] kb;
		logic [31:0] ki;
		outs.delete();
		case (r.req_type)
			REQ_TICK: begin
				now_ticks = now_ticks + 1;
				while (outs.size() < MaxResults) begin
					best = -1;
					for (int i = 0; i < NumJobs; i++) begin
						if (!job_live[i] || !((job_due[i] - now_ticks) & SignBit))
							continue;
						if (best < 0) begin
							best = i;
							continue;
						end
						ki = (job_due[i] - now_ticks) ^ SignBit;
						kb = (job_due[best] - now_ticks) ^ SignBit;
						if (ki < kb || (ki == kb && ((job_seq[i] - job_seq[best]) & SignBit)))
							best = i;
					end
					if (best < 0)
						break;
					outs.push_back(mk_rsp(KIND_FIRED, job_ident[best], 1'b1, 1'b0));
					if (job_reload[best] != 0) begin
						job_due[best] = now_ticks + job_reload[best];
						job_seq[best] = next_seq;
						next_seq = next_seq + 1;
					end else begin
						job_live[best] = 1'b0;
					end
				end
			end
			REQ_ONCE, REQ_RECUR: begin
				slot = -1;
				for (int i = 0; i < NumJobs; i++)
					if (!job_live[i] && slot < 0)
						slot = i;
				if (slot < 0) begin
					outs.push_back(mk_rsp(KIND_SCHED, '0, 1'b0, 1'b0));
				end else begin
					outs.push_back(mk_rsp(KIND_SCHED, next_ident, 1'b1, 1'b0));
					job_live[slot] = 1'b1;
					job_ident[slot] = next_ident;
					job_due[slot] = now_ticks + r.delay;
					job_reload[slot] = (r.req_type == REQ_RECUR) ? r.period : '0;
					job_seq[slot] = next_seq;
					next_seq = next_seq + 1;
					next_ident = next_ident + 1;
					if (next_ident == 0)
						next_ident = 1;
				end
			end
			REQ_CANCEL: begin
				slot = lookup_job(r.job_id);
				if (slot >= 0)
					job_live[slot] = 1'b0;
				outs.push_back(mk_rsp(KIND_CANCEL, r.job_id, slot >= 0, 1'b0));
			end
			REQ_QUERY: begin
				slot = lookup_job(r.job_id);
				outs.push_back(mk_rsp(KIND_QUERY, r.job_id, slot >= 0, 1'b0));
			end
			default: ;
		endcase
		if (outs.size() > 0)
			outs[outs.size() - 1].last = 1'b1;
	endfunction

	// Offers one request after a random gap and books its results on acceptance.
	task automatic send_request(step_row_t s);
		int gap;
		rsp_t outs[$];
		gap = quiet ? 0 : $urandom_range(0, 11);
		if (gap > 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req <= s.r;
		req_valid <= 1'b1;
		do @(posedge clk); while (req_stall);
		apply_request(s.r, outs);
		if (s.typed) begin
			if (s.count > 0)
				pending_rsps.push_back(s.want);
		end else begin
			foreach (outs[i])
				pending_rsps.push_back(outs[i]);
		end
	endtask

	task automatic wait_drained();
		req_valid <= 1'b0;
		while (pending_rsps.size() > 0)
			@(posedge clk);
	endtask

	function automatic step_row_t row(req_t r, bit typed, int count, rsp_t want);
		step_row_t s;
		s.r = r;
		s.typed = typed;
		s.count = count;
		s.want = want;
		return s;
	endfunction

	function automatic step_row_t random_row();
		int pick;
		logic [30:0] d;
		logic [30:0] p;
		logic [30:0] id;
		logic [2:0] t;
		pick = $urandom_range(0, 99);
		d = ($urandom_range(0, 9) == 0) ? 31'($urandom) : 31'($urandom_range(0, 24));
		p = ($urandom_range(0, 9) == 0) ? 31'($urandom) : 31'($urandom_range(0, 12));
		if ($urandom_range(0, 7) == 0)
			id = 31'($urandom);
		else if (next_ident > 24)
			id = next_ident - 31'($urandom_range(0, 24));
		else
			id = 31'($urandom_range(0, next_ident));
		if (pick < 40)
			t = REQ_TICK;
		else if (pick < 58)
			t = REQ_ONCE;
		else if (pick < 74)
			t = REQ_RECUR;
		else if (pick < 85)
			t = REQ_CANCEL;
		else if (pick < 97)
			t = REQ_QUERY;
		else
			t = 3'(int'(REQ_QUERY) + $urandom_range(1, 3));
		return row(mk_req(t, d, p, id), 1'b0, 0, '0);
	endfunction

	// Receiver: random stall before each result, with a long hold-off on demand.
	initial begin
		int n;
		rsp_stall <= 1'b0;
		forever begin
			if (hold_receiver) begin
				hold_receiver = 1'b0;
				n = LongHold;
			end else begin
				n = quiet ? 0 : $urandom_range(0, 11);
			end
			if (n > 0) begin
				rsp_stall <= 1'b1;
				repeat (n) @(posedge clk);
				rsp_stall <= 1'b0;
			end
			do @(posedge clk); while (!rsp_valid);
			if (pending_rsps.size() == 0) begin
				$display("%0t: unexpected result %p", $time, rsp);
				errors++;
			end else begin
				rsp_t w;
				w = pending_rsps.pop_front();
				if (rsp.kind !== w.kind || rsp.result_id !== w.result_id ||
						rsp.ok !== w.ok || rsp.last !== w.last) begin
					$display("%0t: expected %p, got %p", $time, w, rsp);
					errors++;
				end
			end
		end
	end

	initial begin
		errors = 0;
		cycles = 0;
		quiet = 1'b0;
		hold_receiver = 1'b0;
		arst_n <= 1'b0;
		req_valid <= 1'b0;
		req <= '0;
		foreach (job_live[i])
			job_live[i] = 1'b0;
		now_ticks = 0;
		next_ident = 1;
		next_seq = 0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: empty table, misses, id zero, extremes, unknown codes,
		// a full table and a tick that fires the most results at once.
		steps.push_back(row(mk_req(REQ_TICK, '0, '0, '0), 1, 0, '0));
		steps.push_back(row(mk_req(REQ_QUERY, '0, '0, '0), 1, 1,
			mk_rsp(KIND_QUERY, '0, 1'b0, 1'b1)));
		steps.push_back(row(mk_req(REQ_CANCEL, '0, '0, AllOnes31), 1, 1,
			mk_rsp(KIND_CANCEL, AllOnes31, 1'b0, 1'b1)));
		steps.push_back(row(mk_req(REQ_ONCE, '0, '0, '0), 1, 1,
			mk_rsp(KIND_SCHED, 31'd1, 1'b1, 1'b1)));
		steps.push_back(row(mk_req(REQ_TICK, '0, '0, '0), 1, 1,
			mk_rsp(KIND_FIRED, 31'd1, 1'b1, 1'b1)));
		steps.push_back(row(mk_req(REQ_RECUR, '0, AllOnes31, '0), 1, 1,
			mk_rsp(KIND_SCHED, 31'd2, 1'b1, 1'b1)));
		steps.push_back(row(mk_req(REQ_ONCE, AllOnes31, AllOnes31, AllOnes31), 1, 1,
			mk_rsp(KIND_SCHED, 31'd3, 1'b1, 1'b1)));
		steps.push_back(row(mk_req(REQ_QUERY, '0, '0, 31'd2), 1, 1,
			mk_rsp(KIND_QUERY, 31'd2, 1'b1, 1'b1)));
		steps.push_back(row(mk_req(REQ_CANCEL, '0, '0, 31'd3), 1, 1,
			mk_rsp(KIND_CANCEL, 31'd3, 1'b1, 1'b1)));
		steps.push_back(row(mk_req(REQ_QUERY, '0, '0, 31'd3), 1, 1,
			mk_rsp(KIND_QUERY, 31'd3, 1'b0, 1'b1)));
		for (int k = 1; k <= 3; k++)
			steps.push_back(row(mk_req(3'(int'(REQ_QUERY) + k), AllOnes31, AllOnes31,
				AllOnes31), 1, 0, '0));
		steps.push_back(row(mk_req(REQ_RECUR, '0, '0, '0), 0, 0, '0));
		for (int k = 0; k < NumJobs - 2; k++)
			steps.push_back(row(mk_req(REQ_ONCE, '0, '0, '0), 0, 0, '0));
		steps.push_back(row(mk_req(REQ_ONCE, '0, '0, '0), 1, 1,
			mk_rsp(KIND_SCHED, '0, 1'b0, 1'b1)));
		steps.push_back(row(mk_req(REQ_TICK, '0, '0, '0), 0, 0, '0));
		steps.push_back(row(mk_req(REQ_TICK, '0, '0, '0), 0, 0, '0));
		foreach (steps[i])
			send_request(steps[i]);
		wait_drained();

		for (int n = 0; n < RandomRequests; n++) begin
			if (n == 120)
				hold_receiver = 1'b1;
			if (n == 250)
				wait_drained();
			quiet = (n >= 300 && n < 340);
			send_request(random_row());
		end
		quiet = 1'b0;
		wait_drained();
		repeat (100) @(posedge clk);
		if (errors == 0 && pending_rsps.size() == 0) begin
			$display("** timer_job_queue: PASSED **");
		end else begin
			$display("** timer_job_queue: FAILED **");
		end
		$finish;
	end

endmodule
